[rtl/core/ffpa_pkg.sv]
`timescale 1ns / 1ps

package ffpa_pkg;

   localparam int TABLE_ENTRIES = 1024;
   localparam int PAGE_SHIFT    = 12;
   localparam int PAGE_BYTES    = 1 << PAGE_SHIFT;

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int MARK_W = 3;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [MARK_W-1:0] {
      MARK_FREE    = 3'd0,
      MARK_LONE    = 3'd1,
      MARK_FIRST   = 3'd2,
      MARK_INTERIM = 3'd3,
      MARK_LAST    = 3'd4
   } mark_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_NO_SPACE   = 3'd1,
      ST_ZERO_SIZE  = 3'd2,
      ST_MISALIGNED = 3'd3,
      ST_OUTSIDE    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_SWEEP,
      S_IDLE,
      S_SCAN,
      S_MARK,
      S_FREE_SCAN,
      S_REPLY
   } state_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] size_bytes;
      logic [31:0] free_address;
   } req_item_type;

   typedef struct packed {
      logic [31:0] granted_address;
      logic [2:0]  status;
   } rsp_item_type;

   typedef struct packed {
      logic start;
      logic take;
   } engine_ctl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } engine_sts_type;

endpackage

[rtl/core/ffpa_ram.sv]
`timescale 1ns / 1ps

module ffpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/ffpa_engine.sv]
`timescale 1ns / 1ps

module ffpa_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  ffpa_pkg::engine_ctl_type ctl,
   input  ffpa_pkg::req_item_type item,
   input  logic [31:0]            heap_base,
   output ffpa_pkg::engine_sts_type sts,
   output ffpa_pkg::rsp_item_type result
);

   localparam int IW = ffpa_pkg::IDX_W;
   localparam int CW = ffpa_pkg::CNT_W;
   localparam int SH = ffpa_pkg::PAGE_SHIFT;
   localparam logic [CW-1:0] LAST_IDX = CW'(ffpa_pkg::TABLE_ENTRIES - 1);
   localparam logic [CW-1:0] ENTRIES  = CW'(ffpa_pkg::TABLE_ENTRIES);

   ffpa_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic                data_valid_ff, data_valid_in;
   logic [IW-1:0]       data_idx_ff, data_idx_in;
   logic [CW-1:0]       pages_ff, pages_in;
   logic [CW-1:0]       run_len_ff, run_len_in;
   logic [CW-1:0]       run_start_ff, run_start_in;
   logic [CW-1:0]       k_ff, k_in;
   logic                clear_reply_ff, clear_reply_in;
   logic [2:0]          status_ff, status_in;
   logic [31:0]         addr_ff, addr_in;

   logic                     wr_en;
   logic [IW-1:0]            wr_addr;
   logic [ffpa_pkg::MARK_W-1:0] wr_data;
   logic [IW-1:0]            rd_addr;
   logic [ffpa_pkg::MARK_W-1:0] rd_data;

   logic [32:0]   pages_wide;
   logic [31:0]   offset;
   logic [31:0]   page_wide;
   logic [CW-1:0] page_idx;
   logic [CW-1:0] run_len_next;

   ffpa_ram #(
      .WIDTH (ffpa_pkg::MARK_W),
      .DEPTH (ffpa_pkg::TABLE_ENTRIES)
   ) u_marks (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ffpa_pkg::S_SWEEP;
         idx_ff         <= '0;
         data_valid_ff  <= 1'b0;
         clear_reply_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         data_valid_ff  <= data_valid_in;
         clear_reply_ff <= clear_reply_in;
      end
      data_idx_ff  <= data_idx_in;
      pages_ff     <= pages_in;
      run_len_ff   <= run_len_in;
      run_start_ff <= run_start_in;
      k_ff         <= k_in;
      status_ff    <= status_in;
      addr_ff      <= addr_in;
   end

   assign pages_wide   = ({1'b0, item.size_bytes} + 33'(ffpa_pkg::PAGE_BYTES - 1)) >> SH;
   assign offset       = item.free_address - heap_base;
   assign page_wide    = offset >> SH;
   assign page_idx     = CW'(page_wide);
   assign run_len_next = (rd_data == ffpa_pkg::MARK_FREE) ? run_len_ff + 1'b1 : '0;

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      data_valid_in  = 1'b0;
      data_idx_in    = data_idx_ff;
      pages_in       = pages_ff;
      run_len_in     = run_len_ff;
      run_start_in   = run_start_ff;
      k_in           = k_ff;
      clear_reply_in = clear_reply_ff;
      status_in      = status_ff;
      addr_in        = addr_ff;
      wr_en          = 1'b0;
      wr_addr        = idx_ff[IW-1:0];
      wr_data        = ffpa_pkg::MARK_FREE;
      rd_addr        = idx_ff[IW-1:0];
      sts.idle       = 1'b0;
      sts.done       = 1'b0;

      case (state_ff)
         ffpa_pkg::S_SWEEP: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[IW-1:0];
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = clear_reply_ff ? ffpa_pkg::S_REPLY : ffpa_pkg::S_IDLE;
            end
         end

         ffpa_pkg::S_IDLE: begin
            sts.idle = 1'b1;
            if (ctl.start) begin
               status_in      = ffpa_pkg::ST_OK;
               addr_in        = '0;
               clear_reply_in = 1'b0;
               state_in       = ffpa_pkg::S_REPLY;
               case (item.cmd)
                  ffpa_pkg::CMD_ALLOC: begin
                     if (item.size_bytes == '0) begin
                        status_in = ffpa_pkg::ST_ZERO_SIZE;
                     end else if (pages_wide > 33'(ffpa_pkg::TABLE_ENTRIES)) begin
                        status_in = ffpa_pkg::ST_NO_SPACE;
                     end else begin
                        pages_in     = CW'(pages_wide);
                        run_len_in   = '0;
                        run_start_in = '0;
                        idx_in       = '0;
                        state_in     = ffpa_pkg::S_SCAN;
                     end
                  end
                  ffpa_pkg::CMD_FREE: begin
                     if (item.free_address < heap_base ||
                         page_wide >= 32'(ffpa_pkg::TABLE_ENTRIES)) begin
                        status_in = ffpa_pkg::ST_OUTSIDE;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = page_idx[IW-1:0];
                        if (page_idx != LAST_IDX) begin
                           rd_addr       = IW'(page_idx + 1'b1);
                           data_valid_in = 1'b1;
                           data_idx_in   = IW'(page_idx + 1'b1);
                           idx_in        = page_idx + CW'(2);
                           state_in      = ffpa_pkg::S_FREE_SCAN;
                        end
                     end
                  end
                  ffpa_pkg::CMD_CLEAR: begin
                     if (heap_base[SH-1:0] != '0) begin
                        status_in = ffpa_pkg::ST_MISALIGNED;
                     end else begin
                        idx_in         = '0;
                        clear_reply_in = 1'b1;
                        state_in       = ffpa_pkg::S_SWEEP;
                     end
                  end
                  default: begin
                     status_in = ffpa_pkg::ST_OK;
                  end
               endcase
            end
         end

         ffpa_pkg::S_SCAN: begin
            if (idx_ff < ENTRIES) begin
               rd_addr       = idx_ff[IW-1:0];
               data_valid_in = 1'b1;
               data_idx_in   = idx_ff[IW-1:0];
               idx_in        = idx_ff + 1'b1;
            end
            if (data_valid_ff) begin
               run_len_in = run_len_next;
               if (rd_data != ffpa_pkg::MARK_FREE) begin
                  run_start_in = CW'(data_idx_ff) + 1'b1;
               end
               if (run_len_next == pages_ff) begin
                  k_in     = '0;
                  state_in = ffpa_pkg::S_MARK;
               end else if (CW'(data_idx_ff) == LAST_IDX) begin
                  status_in = ffpa_pkg::ST_NO_SPACE;
                  state_in  = ffpa_pkg::S_REPLY;
               end
            end
         end

         ffpa_pkg::S_MARK: begin
            wr_en   = 1'b1;
            wr_addr = IW'(run_start_ff + k_ff);
            if (pages_ff == CW'(1)) begin
               wr_data = ffpa_pkg::MARK_LONE;
            end else if (k_ff == '0) begin
               wr_data = ffpa_pkg::MARK_FIRST;
            end else if (k_ff == pages_ff - 1'b1) begin
               wr_data = ffpa_pkg::MARK_LAST;
            end else begin
               wr_data = ffpa_pkg::MARK_INTERIM;
            end
            k_in = k_ff + 1'b1;
            if (k_ff == pages_ff - 1'b1) begin
               status_in = ffpa_pkg::ST_OK;
               addr_in   = heap_base + (32'(run_start_ff) << SH);
               state_in  = ffpa_pkg::S_REPLY;
            end
         end

         ffpa_pkg::S_FREE_SCAN: begin
            if (idx_ff < ENTRIES) begin
               rd_addr       = idx_ff[IW-1:0];
               data_valid_in = 1'b1;
               data_idx_in   = idx_ff[IW-1:0];
               idx_in        = idx_ff + 1'b1;
            end
            if (rd_data == ffpa_pkg::MARK_INTERIM || rd_data == ffpa_pkg::MARK_LAST) begin
               wr_en   = 1'b1;
               wr_addr = data_idx_ff;
               if (CW'(data_idx_ff) == LAST_IDX) begin
                  state_in = ffpa_pkg::S_REPLY;
               end
            end else begin
               state_in = ffpa_pkg::S_REPLY;
            end
         end

         ffpa_pkg::S_REPLY: begin
            sts.done = 1'b1;
            if (ctl.take) begin
               state_in = ffpa_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = ffpa_pkg::S_IDLE;
         end
      endcase
   end

   assign result.granted_address = addr_ff;
   assign result.status          = status_ff;

endmodule

[rtl/core/first_fit_page_allocator_top.sv]
`timescale 1ns / 1ps

// First-fit page allocator over a 1024-entry mark table held in a single
// RAM of 4096-byte pages, walked one entry per cycle by one sequencer. After
// reset the table is cleared in one pass during which no item is taken. An
// allocate scans the table from entry 0 through the RAM read port until a
// free run is long enough, then writes the run one mark a cycle. A free
// clears the released run entry by entry; a clear sweeps all 1024 entries;
// rejected items and unknown commands go straight to the reply. One item is
// worked at a time; the result sits in an output register, so the next item
// may be taken while it waits. heap_base must be written through csr_ only
// while the block is idle; the block itself does not enforce this.
module first_fit_page_allocator_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ffpa_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ffpa_pkg::rsp_item_type rsp_item,
   input  logic                   csr_write_enable,
   input  logic [31:0]            csr_write_data
);

   logic [31:0]              heap_base_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   ffpa_pkg::rsp_item_type   rsp_item_ff, rsp_item_in;
   ffpa_pkg::engine_ctl_type ctl;
   ffpa_pkg::engine_sts_type sts;
   ffpa_pkg::rsp_item_type   result;

   ffpa_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .item      (req_item),
      .heap_base (heap_base_ff),
      .sts       (sts),
      .result    (result)
   );

   assign req_stall = !sts.idle;
   assign ctl.start = req_valid && sts.idle;
   assign ctl.take  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (sts.done && ctl.take) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            heap_base_ff <= csr_write_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

[sim/ffpa_checker.sv]
`timescale 1ns / 1ps

module ffpa_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  ffpa_pkg::req_item_type req_item,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  ffpa_pkg::rsp_item_type rsp_item,
   input  logic                   csr_write_enable,
   input  logic [31:0]            csr_write_data,
   output int                     mismatch_count,
   output int                     outstanding
);

   import ffpa_pkg::*;

   mark_type     page_state [TABLE_ENTRIES];
   logic [31:0]  heap_base_copy = '0;
   rsp_item_type pending_replies [$];
   int           failures = 0;

   function automatic rsp_item_type predict_reply(input req_item_type it);
      rsp_item_type           r;
      logic [32:0]            rounded;
      logic [32-PAGE_SHIFT:0] pages;
      logic [31:0]            offset;
      int                     run_start;
      int                     run_len;
      int                     pg;
      r.granted_address = '0;
      r.status          = ST_OK;
      case (it.cmd)
         CMD_ALLOC: begin
            rounded = {1'b0, it.size_bytes} + 33'(PAGE_BYTES - 1);
            pages   = rounded[32:PAGE_SHIFT];
            if (it.size_bytes == '0) begin
               r.status = ST_ZERO_SIZE;
            end else if (pages > TABLE_ENTRIES) begin
               r.status = ST_NO_SPACE;
            end else begin
               run_start = 0;
               run_len   = 0;
               for (int i = 0; i < TABLE_ENTRIES && run_len != pages; i++) begin
                  if (page_state[i] != MARK_FREE) begin
                     run_len   = 0;
                     run_start = i + 1;
                  end else begin
                     run_len++;
                  end
               end
               if (run_len != pages) begin
                  r.status = ST_NO_SPACE;
               end else begin
                  for (int k = 0; k < run_len; k++) begin
                     if (run_len == 1)
                        page_state[run_start + k] = MARK_LONE;
                     else if (k == 0)
                        page_state[run_start + k] = MARK_FIRST;
                     else if (k == run_len - 1)
                        page_state[run_start + k] = MARK_LAST;
                     else
                        page_state[run_start + k] = MARK_INTERIM;
                  end
                  r.granted_address = heap_base_copy + (32'(run_start) << PAGE_SHIFT);
               end
            end
         end
         CMD_FREE: begin
            offset = it.free_address - heap_base_copy;
            if (it.free_address < heap_base_copy) begin
               r.status = ST_OUTSIDE;
            end else if ((offset >> PAGE_SHIFT) >= TABLE_ENTRIES) begin
               r.status = ST_OUTSIDE;
            end else begin
               pg = int'(offset >> PAGE_SHIFT);
               page_state[pg] = MARK_FREE;
               for (int i = pg + 1; i < TABLE_ENTRIES; i++) begin
                  if (page_state[i] != MARK_INTERIM && page_state[i] != MARK_LAST) break;
                  page_state[i] = MARK_FREE;
               end
            end
         end
         CMD_CLEAR: begin
            if (heap_base_copy[PAGE_SHIFT-1:0] != '0)
               r.status = ST_MISALIGNED;
            else
               foreach (page_state[i]) page_state[i] = MARK_FREE;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         foreach (page_state[i]) page_state[i] = MARK_FREE;
         heap_base_copy = '0;
         pending_replies.delete();
      end else begin
         if (csr_write_enable) heap_base_copy = csr_write_data;
         if (rsp_valid && !rsp_stall) begin
            if (pending_replies.size() == 0) begin
               if (failures < 10)
                  $display("unexpected reply: addr %h status %0d",
                           rsp_item.granted_address, rsp_item.status);
               failures++;
            end else begin
               want = pending_replies.pop_front();
               if (rsp_item.granted_address !== want.granted_address ||
                   rsp_item.status !== want.status) begin
                  if (failures < 10)
                     $display("reply mismatch: expected addr %h status %0d, got addr %h status %0d",
                              want.granted_address, want.status,
                              rsp_item.granted_address, rsp_item.status);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall) pending_replies.push_back(predict_reply(req_item));
      end
      mismatch_count <= failures;
      outstanding    <= pending_replies.size();
   end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   import ffpa_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic         clock            = 1'b0;
   logic         reset            = 1'b1;
   logic         req_valid        = 1'b0;
   logic         req_stall;
   req_item_type req_item         = '0;
   logic         rsp_valid;
   logic         rsp_stall        = 1'b0;
   rsp_item_type rsp_item;
   logic         csr_write_enable = 1'b0;
   logic [31:0]  csr_write_data   = '0;

   int           mismatch_count;
   int           outstanding;

   int           send_idle_pct    = 8;
   int           recv_idle_pct    = 62;
   logic [31:0]  heap_base_now    = '0;
   logic [1:0]   sent_cmds [$];
   logic [31:0]  live_grants [$];
   logic [1:0]   done_cmd;

   logic [31:0]  phase_bases [6] = '{32'h8000_0000, 32'hFFC0_1000, 32'h1234_5678,
                                     32'hFFFF_FFFF, 32'h0000_0000, 32'h0040_0000};
   int           sender_idle [3]   = '{8, 62, 0};
   int           receiver_idle [3] = '{62, 8, 0};

   always #2 clock = ~clock;

   first_fit_page_allocator_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   ffpa_checker reply_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // keep the addresses handed out so that frees mostly hit live runs
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall && sent_cmds.size() != 0) begin
         done_cmd = sent_cmds.pop_front();
         if (done_cmd == CMD_ALLOC && rsp_item.status == ST_OK)
            live_grants.push_back(rsp_item.granted_address);
      end
   end

   function automatic req_item_type make_request(input logic [1:0] op,
                                                 input logic [31:0] size,
                                                 input logic [31:0] addr);
      req_item_type it;
      it.cmd          = op;
      it.size_bytes   = size;
      it.free_address = addr;
      return it;
   endfunction

   task automatic send_request(input req_item_type it);
      req_item  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sent_cmds.push_back(it.cmd);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // drain every reply, then write the heap base while the block is idle
   task automatic settle_and_configure(input logic [31:0] base);
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0 || req_stall);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= base;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      heap_base_now = base;
   endtask

   task automatic pick_request(output req_item_type it);
      int roll;
      int pick;
      int idx;
      roll            = $urandom_range(99);
      it.cmd          = CMD_ALLOC;
      it.size_bytes   = $urandom;
      it.free_address = $urandom;
      if (roll < 47) begin
         pick = $urandom_range(99);
         if (pick < 3)
            it.size_bytes = '0;
         else if (pick < 8)
            it.size_bytes = $urandom;
         else if (pick < 14)
            it.size_bytes = $urandom_range(1, 16) << PAGE_SHIFT;
         else if (pick < 24)
            it.size_bytes = $urandom_range(8 * PAGE_BYTES, 48 * PAGE_BYTES);
         else
            it.size_bytes = $urandom_range(1, 6 * PAGE_BYTES);
      end else if (roll < 91) begin
         it.cmd = CMD_FREE;
         pick   = $urandom_range(99);
         if (pick < 60 && live_grants.size() != 0) begin
            idx             = $urandom_range(live_grants.size() - 1);
            it.free_address = live_grants[idx];
            live_grants.delete(idx);
            if ($urandom_range(3) == 0)
               it.free_address += $urandom_range(PAGE_BYTES - 1);
         end else if (pick < 85) begin
            it.free_address = heap_base_now + ($urandom_range(63) << PAGE_SHIFT)
                              + $urandom_range(PAGE_BYTES - 1);
         end else if (pick < 92) begin
            it.free_address = heap_base_now - $urandom_range(1, 2 * PAGE_BYTES);
         end else if (pick < 96) begin
            it.free_address = heap_base_now + (TABLE_ENTRIES << PAGE_SHIFT)
                              + $urandom_range(4 * PAGE_BYTES);
         end
      end else if (roll < 94) begin
         it.cmd = CMD_CLEAR;
      end else begin
         it.cmd = CMD_UNUSED;
      end
   endtask

   initial begin
      req_item_type it;
      int           issued;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      settle_and_configure(32'h0000_0000);
      send_request(make_request(CMD_ALLOC, 32'd0, $urandom));
      send_request(make_request(CMD_ALLOC, 32'd1, $urandom));
      send_request(make_request(CMD_ALLOC, 32'd4096, $urandom));
      send_request(make_request(CMD_ALLOC, 32'd4097, $urandom));
      send_request(make_request(CMD_ALLOC, 32'd12288, $urandom));
      send_request(make_request(CMD_FREE, $urandom, 32'h0000_507B));
      send_request(make_request(CMD_FREE, $urandom, 32'h0000_2000));
      send_request(make_request(CMD_ALLOC, 32'hFFFF_FFFF, $urandom));
      send_request(make_request(CMD_ALLOC, 32'h0040_0000, $urandom));
      send_request(make_request(CMD_FREE, $urandom, 32'hFFFF_FFFF));
      send_request(make_request(CMD_FREE, $urandom, 32'h0040_0000));
      send_request(make_request(CMD_FREE, $urandom, 32'h003F_FFFF));
      send_request(make_request(CMD_UNUSED, $urandom, $urandom));
      send_request(make_request(CMD_CLEAR, $urandom, $urandom));
      send_request(make_request(CMD_ALLOC, 32'h0040_0000, $urandom));
      send_request(make_request(CMD_ALLOC, 32'd1, $urandom));
      send_request(make_request(CMD_FREE, $urandom, 32'h0000_0000));
      send_request(make_request(CMD_CLEAR, $urandom, $urandom));

      // misaligned base blocks clear only
      settle_and_configure(32'h0000_1001);
      send_request(make_request(CMD_CLEAR, $urandom, $urandom));
      send_request(make_request(CMD_FREE, $urandom, 32'h0000_0000));
      send_request(make_request(CMD_ALLOC, 32'd1, $urandom));
      send_request(make_request(CMD_FREE, $urandom, 32'h0000_2000));

      // granted addresses wrap past the top of the address space
      settle_and_configure(32'hFFFF_F000);
      send_request(make_request(CMD_ALLOC, 32'd8192, $urandom));
      send_request(make_request(CMD_ALLOC, 32'd1, $urandom));
      send_request(make_request(CMD_FREE, $urandom, 32'h0000_1000));
      send_request(make_request(CMD_CLEAR, $urandom, $urandom));

      for (int seg = 0; seg < 6; seg++) begin
         settle_and_configure(phase_bases[seg]);
         send_idle_pct = sender_idle[seg / 2];
         recv_idle_pct = receiver_idle[seg / 2];
         issued = 0;
         while (issued < 86) begin
            pick_request(it);
            send_request(it);
            if (it.cmd != CMD_UNUSED) issued++;
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (1100) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
